// ----- design/kwm_pkg.sv -----
// ----------------------------------------------------------------------------
// kwm_pkg: shared definitions for the k-way merge with duplicate removal
// Holds the sequencer state codes, the result kinds, the register map and
// the control bundle that drives the shared minimum-search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

  // Widths fixed by the item and register formats.
  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned SIDX_W    = 3;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned ACTIVE_W  = 4;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;

  // Register map: byte addresses on the configuration port.
  localparam logic [APB_AW-1:0] ADDR_ACTIVE_STREAMS = 3'd0;

  // Reset value of the active stream count.
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  // Result kinds.
  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SCAN  = 4'b0100,
    S_EMIT  = 4'b1000
  } kwm_state_t;

  // Control bundle from the sequencer to the minimum-search unit.
  typedef struct packed {
    logic start;  // clear the running minimum before a new scan
    logic step;   // fold the presented front into the running minimum
  } kwm_scan_ctl_t;

endpackage

`default_nettype wire

// ----- design/kwm_front_mem.sv -----
// ----------------------------------------------------------------------------
// kwm_front_mem: front value store
// One entry per stream holding its current front value. One write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_front_mem #(
  parameter int unsigned NUM_STREAMS = 8,
  parameter int unsigned IDX_W       = 3
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [IDX_W-1:0]              waddr,
  input  wire logic [kwm_pkg::VALUE_W-1:0]   wdata,
  input  wire logic                          re,
  input  wire logic [IDX_W-1:0]              raddr,
  output logic      [kwm_pkg::VALUE_W-1:0]   rdata_r
);

  logic [kwm_pkg::VALUE_W-1:0] mem [NUM_STREAMS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/kwm_min_scan.sv -----
// ----------------------------------------------------------------------------
// kwm_min_scan: shared minimum-search unit
// A single 64-bit comparator folds one front per cycle into a running
// minimum and collects the mask of streams whose front equals it.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_min_scan #(
  parameter int unsigned NUM_STREAMS = 8,
  parameter int unsigned IDX_W       = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire kwm_pkg::kwm_scan_ctl_t        ctl,
  input  wire logic [kwm_pkg::VALUE_W-1:0]   data,
  input  wire logic [IDX_W-1:0]              idx,
  output logic      [kwm_pkg::VALUE_W-1:0]   min_value_r,
  output logic      [NUM_STREAMS-1:0]        min_mask_r
);

  logic                   any_r;
  logic                   any_nxt;
  logic [kwm_pkg::VALUE_W-1:0] min_value_nxt;
  logic [NUM_STREAMS-1:0] min_mask_nxt;
  logic                   lt;
  logic                   eq;
  logic [NUM_STREAMS-1:0] onehot;

  // The shared comparator.
  assign lt     = (data < min_value_r);
  assign eq     = (data == min_value_r);
  assign onehot = {{(NUM_STREAMS-1){1'b0}}, 1'b1} << idx;

  // Running minimum and the mask of streams that hold it.
  always_comb begin
    any_nxt       = any_r;
    min_value_nxt = min_value_r;
    min_mask_nxt  = min_mask_r;
    if (ctl.start) begin
      any_nxt      = 1'b0;
      min_mask_nxt = '0;
    end else if (ctl.step) begin
      if (!any_r || lt) begin
        any_nxt       = 1'b1;
        min_value_nxt = data;
        min_mask_nxt  = onehot;
      end else if (eq) begin
        min_mask_nxt = min_mask_r | onehot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r      <= 1'b0;
      min_mask_r <= '0;
    end else begin
      any_r      <= any_nxt;
      min_mask_r <= min_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    min_value_r <= min_value_nxt;
  end

endmodule

`default_nettype wire

// ----- design/k_way_merge_dedup.sv -----
// ----------------------------------------------------------------------------
// k_way_merge_dedup: k-way merge of ascending streams with duplicate removal
// Sequence: the transfer that completes the refills is followed by check, a scan
// of every front through the one comparator, and emit, which presents the merged
// result; the done result skips the scan. Outside idle the input stalls, so no new
// item is taken before the last one has gone through check (and scan and emit).
// Reset (rst_n, synchronous, active low): active_streams returns to 8, the
// first streams are live and pending; the front store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_merge_dedup #(
  parameter int unsigned NUM_STREAMS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [kwm_pkg::SIDX_W-1:0]         in_stream_index,
  input  wire logic [kwm_pkg::VALUE_W-1:0]        in_value,
  input  wire logic                               in_stream_end,
  // Result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_kind,
  output logic      [kwm_pkg::VALUE_W-1:0]        out_merged_value,
  output logic      [kwm_pkg::MASK_W-1:0]         out_refill_mask,
  // Configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [kwm_pkg::APB_AW-1:0]         paddr,
  input  wire logic [kwm_pkg::APB_DW-1:0]         pwdata,
  output logic      [kwm_pkg::APB_DW-1:0]         prdata,
  output logic                                    pready
);

  localparam int unsigned IDX_W = $clog2(NUM_STREAMS);
  localparam int unsigned CNT_W = $clog2(NUM_STREAMS + 1);

  // Control state
  kwm_pkg::kwm_state_t              state_r, state_nxt;
  logic [kwm_pkg::ACTIVE_W-1:0]     active_r, active_nxt;
  logic [NUM_STREAMS-1:0]           live_r, live_nxt;
  logic [NUM_STREAMS-1:0]           pending_r, pending_nxt;
  logic                             finished_r, finished_nxt;
  logic                             done_sel_r, done_sel_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic                             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]                 rd_idx_r, rd_idx_nxt;
  logic                             out_valid_r, out_valid_nxt;

  // Result payload
  logic                             out_kind_r, out_kind_nxt;
  logic [kwm_pkg::VALUE_W-1:0]      out_value_r, out_value_nxt;
  logic [kwm_pkg::MASK_W-1:0]       out_mask_r, out_mask_nxt;

  // Internal nets
  logic                             in_acc;
  logic                             cfg_wr;
  logic [NUM_STREAMS-1:0]           first_n;
  logic [IDX_W+kwm_pkg::SIDX_W-1:0] sidx_ext;
  logic [IDX_W-1:0]                 widx;
  logic                             sidx_ok;
  logic                             hit;
  logic                             mem_we;
  logic                             rd_en;
  logic [kwm_pkg::VALUE_W-1:0]      rd_data;
  kwm_pkg::kwm_scan_ctl_t           scan_ctl;
  logic [kwm_pkg::VALUE_W-1:0]      min_value;
  logic [NUM_STREAMS-1:0]           min_mask;
  logic [NUM_STREAMS+kwm_pkg::MASK_W-1:0] min_mask_ext;

  // Handshakes
  assign in_stall = (state_r != kwm_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && (paddr == kwm_pkg::ADDR_ACTIVE_STREAMS);
  assign pready   = 1'b1;
  assign prdata   = {{(kwm_pkg::APB_DW-kwm_pkg::ACTIVE_W){1'b0}}, active_r};

  // Streams below the effective count take part in the merge.
  always_comb begin
    for (int i = 0; i < NUM_STREAMS; i++) begin
      first_n[i] = (int'(active_r) > i);
    end
  end

  // Stream index mapped onto the store, with its range check.
  assign sidx_ext = {{IDX_W{1'b0}}, in_stream_index};
  assign widx     = sidx_ext[IDX_W-1:0];
  assign sidx_ok  = (int'(in_stream_index) < NUM_STREAMS);
  assign hit      = sidx_ok && live_r[widx] && pending_r[widx];

  assign min_mask_ext = {{kwm_pkg::MASK_W{1'b0}}, min_mask};

  // Front store
  kwm_front_mem #(
    .NUM_STREAMS (NUM_STREAMS),
    .IDX_W       (IDX_W)
  ) u_front_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (widx),
    .wdata   (in_value),
    .re      (rd_en),
    .raddr   (cnt_r[IDX_W-1:0]),
    .rdata_r (rd_data)
  );

  // Shared minimum search
  kwm_min_scan #(
    .NUM_STREAMS (NUM_STREAMS),
    .IDX_W       (IDX_W)
  ) u_min_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (scan_ctl),
    .data        (rd_data),
    .idx         (rd_idx_r),
    .min_value_r (min_value),
    .min_mask_r  (min_mask)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    live_nxt      = live_r;
    pending_nxt   = pending_r;
    finished_nxt  = finished_r;
    done_sel_nxt  = done_sel_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_mask_nxt  = out_mask_r;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    scan_ctl      = '0;

    // A waiting result leaves once the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      kwm_pkg::S_IDLE: begin
        // Apply the refill or the end mark of the transferred item.
        if (in_acc) begin
          state_nxt = kwm_pkg::S_CHECK;
          if (!finished_r && hit) begin
            if (in_stream_end) begin
              live_nxt[widx] = 1'b0;
            end else begin
              mem_we = 1'b1;
            end
            pending_nxt[widx] = 1'b0;
          end
        end
      end
      kwm_pkg::S_CHECK: begin
        // Decide whether a result is due.
        if (finished_r || ((pending_r & live_r) != '0)) begin
          state_nxt = kwm_pkg::S_IDLE;
        end else if (live_r == '0) begin
          done_sel_nxt = 1'b1;
          state_nxt    = kwm_pkg::S_EMIT;
        end else begin
          done_sel_nxt   = 1'b0;
          cnt_nxt        = '0;
          scan_ctl.start = 1'b1;
          state_nxt      = kwm_pkg::S_SCAN;
        end
      end
      kwm_pkg::S_SCAN: begin
        // One front read per cycle; the comparator sees it in the cycle after the read.
        scan_ctl.step = rd_vld_r && live_r[rd_idx_r];
        if (cnt_r != CNT_W'(NUM_STREAMS)) begin
          rd_en   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = kwm_pkg::S_EMIT;
        end
      end
      kwm_pkg::S_EMIT: begin
        // Load the result register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = kwm_pkg::S_IDLE;
          if (done_sel_r) begin
            out_kind_nxt  = kwm_pkg::KIND_DONE;
            out_value_nxt = '0;
            out_mask_nxt  = '0;
            finished_nxt  = 1'b1;
          end else begin
            out_kind_nxt  = kwm_pkg::KIND_VALUE;
            out_value_nxt = min_value;
            out_mask_nxt  = min_mask_ext[kwm_pkg::MASK_W-1:0];
            pending_nxt   = min_mask;
          end
        end
      end
      default: begin
        state_nxt = kwm_pkg::S_IDLE;
      end
    endcase

    // A register write restarts the merge; fronts are kept.
    if (cfg_wr) begin
      active_nxt   = pwdata[kwm_pkg::ACTIVE_W-1:0];
      live_nxt     = first_n;
      pending_nxt  = first_n;
      finished_nxt = 1'b0;
      for (int i = 0; i < NUM_STREAMS; i++) begin
        live_nxt[i]    = (int'(pwdata[kwm_pkg::ACTIVE_W-1:0]) > i);
        pending_nxt[i] = (int'(pwdata[kwm_pkg::ACTIVE_W-1:0]) > i);
      end
    end
  end

  // Tag travelling with each front read.
  assign rd_vld_nxt = rd_en;
  assign rd_idx_nxt = cnt_r[IDX_W-1:0];

  // Live set after reset: the first ACTIVE_RESET streams that exist.
  function automatic logic [NUM_STREAMS-1:0] first_n_reset();
    logic [NUM_STREAMS-1:0] m;
    for (int i = 0; i < NUM_STREAMS; i++) begin
      m[i] = (int'(kwm_pkg::ACTIVE_RESET) > i);
    end
    return m;
  endfunction

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kwm_pkg::S_IDLE;
      active_r    <= kwm_pkg::ACTIVE_RESET;
      live_r      <= first_n_reset();
      pending_r   <= first_n_reset();
      finished_r  <= 1'b0;
      done_sel_r  <= 1'b0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      live_r      <= live_nxt;
      pending_r   <= pending_nxt;
      finished_r  <= finished_nxt;
      done_sel_r  <= done_sel_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_mask_r  <= out_mask_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_merged_value = out_value_r;
  assign out_refill_mask  = out_mask_r;

  // Checks
  a_pending_live: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r & ~live_r) == '0)
    else $error("a pending stream is not live");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == kwm_pkg::S_CHECK)
    else $error("transferred item not followed by a check");

  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == kwm_pkg::KIND_DONE |->
      out_value_r == '0 && out_mask_r == '0)
    else $error("done result carries a value or a mask");

  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kwm_pkg::S_EMIT && out_valid_r && out_stall |=>
      state_r == kwm_pkg::S_EMIT && out_valid_r)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking regression for k_way_merge_dedup
// The merge is predicted item by item from the stream fronts, live and
// refill flags kept in a small scoreboard. Every result transfer is compared
// field by field with the oldest prediction. Stimulus opens with a directed
// sweep, then runs random merges under several stream counts and idle
// patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_W     = kwm_pkg::VALUE_W;
  localparam int unsigned MASK_W      = kwm_pkg::MASK_W;
  localparam int unsigned SIDX_W      = kwm_pkg::SIDX_W;
  localparam int unsigned ACTIVE_W    = kwm_pkg::ACTIVE_W;
  localparam int unsigned APB_AW      = kwm_pkg::APB_AW;
  localparam int unsigned APB_DW      = kwm_pkg::APB_DW;

  localparam int unsigned STREAMS     = 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned ITEM_TARGET = 1000;
  localparam int unsigned SETTLE_GAP  = 32;

  typedef struct packed {
    logic                 kind;
    logic [VALUE_W-1:0]   merged_value;
    logic [MASK_W-1:0]    refill_mask;
  } merge_result_t;

  typedef enum int {
    FLOW_FREE,
    FLOW_SENDER_SLOW,
    FLOW_RECEIVER_SLOW,
    FLOW_BOTH_LIGHT
  } flow_t;

  // Tracks the merge state and the results that the block still owes.
  class merge_scoreboard;
    logic [VALUE_W-1:0]  fronts [STREAMS];
    logic [STREAMS-1:0]  live;
    logic [STREAMS-1:0]  pending;
    bit                  finished;
    merge_result_t       merged_due [$];
    int unsigned         errors = 0;
    int unsigned         transfers = 0;
    int unsigned         checked = 0;
    int unsigned         done_seen = 0;

    // A register write restarts the merge; the fronts are kept.
    function void restart(logic [ACTIVE_W-1:0] count);
      int unsigned n;
      n = (count > STREAMS) ? STREAMS : count;
      live     = STREAMS'((9'h1 << n) - 1);
      pending  = live;
      finished = 1'b0;
    endfunction

    // Applies one accepted input item and queues the result it causes.
    function void note_transfer(logic [SIDX_W-1:0] idx, logic [VALUE_W-1:0] val,
                                logic last);
      logic [STREAMS-1:0]  sel;
      logic [STREAMS-1:0]  hit;
      logic [VALUE_W-1:0]  least;
      bit                  seen;
      merge_result_t       r;
      int                  s;
      transfers++;
      if (finished) return;
      sel = STREAMS'(1) << idx;
      if ((live & pending & sel) != '0) begin
        if (last) live &= ~sel;
        else fronts[idx] = val;
        pending &= ~sel;
      end
      if ((live & pending) != '0) return;
      // Every stream has ended: one done result, then silence.
      if (live == '0) begin
        finished = 1'b1;
        r.kind = kwm_pkg::KIND_DONE;
        r.merged_value = '0;
        r.refill_mask = '0;
        merged_due = {merged_due, r};
        return;
      end
      // Smallest live front, and every live stream that holds it.
      seen = 1'b0;
      least = '0;
      for (s = 0; s < STREAMS; s++) begin
        if (live[s] && (!seen || fronts[s] < least)) begin
          least = fronts[s];
          seen = 1'b1;
        end
      end
      hit = '0;
      for (s = 0; s < STREAMS; s++) begin
        if (live[s] && fronts[s] == least) hit[s] = 1'b1;
      end
      pending = hit;
      r.kind = kwm_pkg::KIND_VALUE;
      r.merged_value = least;
      r.refill_mask = MASK_W'(hit);
      merged_due = {merged_due, r};
    endfunction

    function void check_result(merge_result_t got);
      merge_result_t want;
      if (merged_due.size() == 0) begin
        $error("unexpected result: kind %0d value %h mask %h",
               got.kind, got.merged_value, got.refill_mask);
        errors++;
        return;
      end
      want = merged_due.pop_front();
      checked++;
      if (want.kind == kwm_pkg::KIND_DONE) done_seen++;
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.merged_value !== want.merged_value) begin
        $error("merged_value: expected %h, actual %h", want.merged_value, got.merged_value);
        errors++;
      end
      if (got.refill_mask !== want.refill_mask) begin
        $error("refill_mask: expected %h, actual %h", want.refill_mask, got.refill_mask);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [SIDX_W-1:0]    in_stream_index;
  logic [VALUE_W-1:0]   in_value;
  logic                 in_stream_end;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_kind;
  logic [VALUE_W-1:0]   out_merged_value;
  logic [MASK_W-1:0]    out_refill_mask;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  merge_scoreboard      sb;
  flow_t                flow;
  logic [VALUE_W-1:0]   stream_tail [STREAMS];
  int unsigned          shaped_items;
  int unsigned          merge_runs;
  int unsigned          cycle_count;

  // Stream counts visited by the random merges, extremes included.
  logic [ACTIVE_W-1:0]  count_plan [16] = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd8, 4'd2, 4'd0, 4'd5,
                                           4'd8, 4'd7, 4'd4, 4'd8, 4'd6, 4'd9, 4'd8, 4'd1};

  k_way_merge_dedup #(
    .NUM_STREAMS (STREAMS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_index  (in_stream_index),
    .in_value         (in_value),
    .in_stream_end    (in_stream_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_merged_value (out_merged_value),
    .out_refill_mask  (out_refill_mask),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run guard: ends a hung simulation.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("k_way_merge_dedup regression: fail");
        $finish;
      end
    end
  end

  function automatic bit sender_idles();
    unique case (flow)
      FLOW_SENDER_SLOW: return $urandom_range(0, 99) < 83;
      FLOW_BOTH_LIGHT:  return $urandom_range(0, 99) < 11;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    unique case (flow)
      FLOW_RECEIVER_SLOW: return $urandom_range(0, 99) < 83;
      FLOW_BOTH_LIGHT:    return $urandom_range(0, 99) < 11;
      default:            return 1'b0;
    endcase
  endfunction

  // Result side: stall is driven on the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= receiver_stalls();
    end
  end

  // Result side: each transfer is checked on the rising edge.
  initial begin
    merge_result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.kind = out_kind;
        got.merged_value = out_merged_value;
        got.refill_mask = out_refill_mask;
        sb.check_result(got);
      end
    end
  end

  // Called on a falling edge; returns on the falling edge after the transfer.
  task automatic send_item(logic [SIDX_W-1:0] idx, logic [VALUE_W-1:0] val, logic last);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_stream_index <= idx;
    in_value <= val;
    in_stream_end <= last;
    do @(posedge clk); while (in_stall);
    sb.note_transfer(idx, val, last);
    @(negedge clk);
  endtask

  // Holds the sender back until every predicted result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.merged_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Idle the block, then write the stream count and read it back.
  task automatic write_active(logic [ACTIVE_W-1:0] count);
    drain();
    repeat (SETTLE_GAP) @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= kwm_pkg::ADDR_ACTIVE_STREAMS;
    pwdata <= APB_DW'(count);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.restart(count);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[ACTIVE_W-1:0] !== count) begin
      $error("active_streams: expected %0d, actual %0d", count, prdata[ACTIVE_W-1:0]);
      sb.errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random content that is not tied to the pending streams.
  task automatic send_noise();
    send_item(SIDX_W'($urandom_range(0, STREAMS - 1)), {$urandom, $urandom},
              $urandom_range(0, 3) == 0);
  endtask

  // Refills a pending stream with its next non-descending value or ends it, or sends noise.
  task automatic send_shaped();
    logic [STREAMS-1:0]  open;
    logic [VALUE_W:0]    grown;
    int                  picks [$];
    int                  s;
    int unsigned         roll;
    open = sb.live & sb.pending;
    for (s = 0; s < STREAMS; s++) begin
      if (open[s]) picks = {picks, s};
    end
    if (picks.size() == 0 || $urandom_range(0, 9) == 0) begin
      send_noise();
      return;
    end
    s = picks[$urandom_range(0, picks.size() - 1)];
    roll = $urandom_range(0, 9);
    if (roll == 9) begin
      send_item(SIDX_W'(s), {$urandom, $urandom}, 1'b1);
    end else begin
      grown = stream_tail[s] + (roll == 0 ? 0 :
                                roll < 6  ? $urandom_range(1, 3) : $urandom_range(4, 1 << 20));
      // A value that would wrap past the top ends the stream instead.
      if (grown[VALUE_W]) begin
        send_item(SIDX_W'(s), stream_tail[s], 1'b1);
      end else begin
        stream_tail[s] = grown[VALUE_W-1:0];
        send_item(SIDX_W'(s), grown[VALUE_W-1:0], 1'b0);
      end
    end
    shaped_items++;
  endtask

  initial begin
    logic [VALUE_W-1:0] base;
    int                 k;
    int                 s;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_stream_index = '0;
    in_value = '0;
    in_stream_end = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    shaped_items = 0;
    merge_runs = 0;
    flow = FLOW_FREE;
    sb = new;
    sb.restart(kwm_pkg::ACTIVE_RESET);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed sweep with all eight streams: zero and all-ones values,
    // duplicates across streams, an early end, an item for a stream that is
    // not waiting, a repeat and a drop within one stream, then the done
    // result and an item after it.
    send_item(3'd0, '0, 1'b0);
    send_item(3'd1, '0, 1'b0);
    send_item(3'd2, {VALUE_W{1'b1}}, 1'b0);
    send_item(3'd3, 64'd5, 1'b0);
    send_item(3'd4, {$urandom, $urandom}, 1'b1);
    send_item(3'd5, 64'd7, 1'b0);
    send_item(3'd6, 64'd5, 1'b0);
    send_item(3'd7, 64'h8000_0000_0000_0000, 1'b0);
    send_item(3'd3, 64'd1, 1'b0);
    send_item(3'd0, '0, 1'b0);
    send_item(3'd1, 64'd9, 1'b0);
    send_item(3'd0, 64'd3, 1'b0);
    send_item(3'd0, 64'd2, 1'b0);
    send_item(3'd0, {VALUE_W{1'b1}}, 1'b0);
    send_item(3'd3, {$urandom, $urandom}, 1'b1);
    send_item(3'd6, {$urandom, $urandom}, 1'b1);
    send_item(3'd5, {VALUE_W{1'b1}}, 1'b0);
    send_item(3'd1, {$urandom, $urandom}, 1'b1);
    send_item(3'd7, {$urandom, $urandom}, 1'b1);
    send_item(3'd0, {$urandom, $urandom}, 1'b1);
    send_item(3'd2, {$urandom, $urandom}, 1'b1);
    send_item(3'd5, {$urandom, $urandom}, 1'b1);
    send_item(3'd2, 64'd1, 1'b0);

    // Random merges: each one under the next stream count of the plan and the next idle pattern.
    for (k = 0; shaped_items < ITEM_TARGET; k++) begin
      flow = FLOW_FREE;
      write_active(count_plan[k % 16]);
      flow = flow_t'(k % 4);
      base = {$urandom, $urandom} >> $urandom_range(0, VALUE_W - 1);
      for (s = 0; s < STREAMS; s++) stream_tail[s] = base + $urandom_range(0, 3);
      while (!sb.finished) begin
        send_shaped();
        if ($urandom_range(0, 49) == 0) drain();
      end
      merge_runs++;
    end

    drain();
    repeat (SETTLE_GAP) @(posedge clk);
    $display("Covered %0d input transfers and %0d checked results (%0d done) over %0d",
             sb.transfers, sb.checked, sb.done_seen, merge_runs + 1);
    $display("merges, with stream counts from 0 to 15 and four idle patterns.");
    if (sb.errors == 0 && sb.merged_due.size() == 0) begin
      $display("k_way_merge_dedup regression: pass");
    end else begin
      $display("k_way_merge_dedup regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/kwm_pkg.sv
design/kwm_front_mem.sv
design/kwm_min_scan.sv
design/k_way_merge_dedup.sv
verif/testbench.sv
